>>> src/text_console_writer_defines.svh
// Assertion helpers used by the checker file.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tcw_pkg.sv
package tcw_pkg;

    localparam int CMD_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 8;
    localparam int CELL_W      = 16;
    localparam int COL_FIELD_W = 7;
    localparam int ROW_FIELD_W = 5;
    localparam int NIBBLE_W    = 4;

    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT_AT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // background black, foreground light grey
    localparam logic [COLOR_W-1:0] RESET_COLOR = {4'h0, 4'h7};
    localparam logic [CELL_W-1:0]  CLEAR_CELL  = {RESET_COLOR, CH_SPACE};

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_PUT_AT,
        OP_READ,
        OP_NOP
    } op_code_t;

    typedef struct packed {
        op_code_t                 opcode;
        logic [CELL_W-1:0]        cell_word;
        logic [COLOR_W-1:0]       color;
        logic [COL_FIELD_W-1:0]   col_x;
        logic [ROW_FIELD_W-1:0]   row_y;
    } tcw_op_t;

    typedef struct packed {
        logic [COL_FIELD_W-1:0] cursor_column;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [CELL_W-1:0]      cell_data;
        logic                   scrolled;
    } tcw_res_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

>>> src/tcw_ifs.sv
interface tcw_req_if import tcw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [CHAR_W-1:0]      character;
    logic [COLOR_W-1:0]     cell_color;
    logic [COL_FIELD_W-1:0] column_x;
    logic [ROW_FIELD_W-1:0] row_y;

    modport source (
        output valid, command, character, cell_color, column_x, row_y,
        input  ready
    );
    modport sink (
        input  valid, command, character, cell_color, column_x, row_y,
        output ready
    );
endinterface

interface tcw_res_if import tcw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [CELL_W-1:0]      cell_data;
    logic                   scrolled;

    modport source (
        output valid, cursor_column, cursor_row, cell_data, scrolled,
        input  ready
    );
    modport sink (
        input  valid, cursor_column, cursor_row, cell_data, scrolled,
        output ready
    );
endinterface

>>> src/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/tcw_front.sv
module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COLOR_W-1:0] cfg_wr_data,
    tcw_req_if.sink            request,
    input  back_status_t       status,
    output logic               push_valid,
    input  logic               push_ready,
    output tcw_op_t            push_op
);

    logic [COLOR_W-1:0] text_color_reg;
    logic               in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else if (cfg_wr_en)
        begin
            text_color_reg <= cfg_wr_data;
        end
    end

    assign in_range = (int'(request.column_x) < COLUMNS) && (int'(request.row_y) < ROWS);

    // hold off input while the back end sweeps the buffer after reset
    assign request.ready = push_ready && !status.clearing;
    assign push_valid    = request.valid && !status.clearing;

    always_comb
    begin
        push_op.cell_word = {text_color_reg, request.character};
        push_op.color     = text_color_reg;
        push_op.col_x     = request.column_x;
        push_op.row_y     = request.row_y;
        push_op.opcode    = OP_NOP;
        unique case (request.command)
            CMD_PUT:
            begin
                if (request.character == CH_NEWLINE)
                begin
                    push_op.opcode = OP_NEWLINE;
                end
                else if (request.character == CH_RETURN)
                begin
                    push_op.opcode = OP_RETURN;
                end
                else
                begin
                    push_op.opcode = OP_PUT;
                end
            end
            CMD_PUT_AT:
            begin
                push_op.cell_word = {request.cell_color, request.character};
                push_op.opcode    = in_range ? OP_PUT_AT : OP_NOP;
            end
            CMD_READ:
            begin
                push_op.opcode = in_range ? OP_READ : OP_NOP;
            end
            default:
            begin
                push_op.opcode = OP_NOP;
            end
        endcase
    end

endmodule

>>> src/tcw_queue.sv
module tcw_queue import tcw_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  tcw_op_t push_op,
    output logic    pop_valid,
    input  logic    pop_ready,
    output tcw_op_t pop_op
);

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    tcw_op_t          slot_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != QCW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> src/tcw_back.sv
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         op_valid,
    output logic         op_ready,
    input  tcw_op_t      op,
    output back_status_t status,
    tcw_res_if.source    result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int KEEP  = COLUMNS * (ROWS - 1);
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int LW    = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_SCROLL,
        ST_FILL
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [LW-1:0]      line_reg, line_next;
    logic [AW-1:0]      scan_reg, scan_next;
    logic [COLOR_W-1:0] blank_reg, blank_next;
    logic               res_valid_reg, res_valid_next;
    tcw_res_t           res_reg, res_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [CELL_W-1:0]  wdata, rdata;
    logic [AW-1:0]      cur_addr, pos_addr;
    logic               out_free, take, wrap;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cur_addr = AW'(line_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign pos_addr = AW'(op.row_y) * AW'(COLUMNS) + AW'(op.col_x);

    assign out_free = !res_valid_reg || result.ready;
    assign op_ready = (state_reg == ST_IDLE) && out_free;
    assign take     = op_valid && op_ready;

    assign status.clearing = (state_reg == ST_CLEAR);

    assign result.valid         = res_valid_reg;
    assign result.cursor_column = res_reg.cursor_column;
    assign result.cursor_row    = res_reg.cursor_row;
    assign result.cell_data     = res_reg.cell_data;
    assign result.scrolled      = res_reg.scrolled;

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        scan_next      = scan_reg;
        blank_next     = blank_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_next       = res_reg;
        we             = 1'b0;
        waddr          = scan_reg;
        wdata          = CLEAR_CELL;
        raddr          = pos_addr;
        wrap           = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                if (scan_reg == AW'(CELLS - 1))
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    res_valid_next     = 1'b1;
                    res_next.cell_data = '0;
                    res_next.scrolled  = 1'b0;
                    unique case (op.opcode)
                        OP_PUT:
                        begin
                            we                 = 1'b1;
                            waddr              = cur_addr;
                            wdata              = op.cell_word;
                            res_next.cell_data = op.cell_word;
                            if (col_reg == CW'(COLUMNS - 1))
                            begin
                                wrap = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            wrap = 1'b1;
                        end
                        OP_RETURN:
                        begin
                            col_next = '0;
                        end
                        OP_PUT_AT:
                        begin
                            we                 = 1'b1;
                            waddr              = pos_addr;
                            wdata              = op.cell_word;
                            res_next.cell_data = op.cell_word;
                        end
                        OP_READ:
                        begin
                            res_valid_next = 1'b0;
                            state_next     = ST_READ_WAIT;
                        end
                        OP_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase

                    if (wrap)
                    begin
                        col_next = '0;
                        if (line_reg == LW'(ROWS - 1))
                        begin
                            res_valid_next    = 1'b0;
                            res_next.scrolled = 1'b1;
                            blank_next        = op.color;
                            scan_next         = '0;
                            state_next        = ST_SCROLL;
                        end
                        else
                        begin
                            line_next = line_reg + 1'b1;
                        end
                    end

                    res_next.cursor_column = COL_FIELD_W'(col_next);
                    res_next.cursor_row    = ROW_FIELD_W'(line_next);
                end
            end
            ST_READ_WAIT:
            begin
                res_next.cell_data = rdata;
                res_valid_next     = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // read one row ahead, write the word read last cycle one row up
                raddr = scan_reg + AW'(COLUMNS);
                if (scan_reg != '0)
                begin
                    we    = 1'b1;
                    waddr = scan_reg - 1'b1;
                    wdata = rdata;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == AW'(KEEP))
                begin
                    // blank fill starts at the first cell of the bottom row
                    scan_next  = AW'(KEEP);
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                we    = 1'b1;
                wdata = {blank_reg, CH_SPACE};
                if (scan_reg == AW'(CELLS - 1))
                begin
                    scan_next      = '0;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            col_reg       <= '0;
            line_reg      <= '0;
            scan_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            scan_reg      <= scan_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blank_reg <= blank_next;
        res_reg   <= res_next;
    end

endmodule

>>> src/text_console_writer.sv
// Text console engine: COLUMNS x ROWS buffer of 16-bit cells plus a cursor.
// request: one word per command (put at cursor, put at position, read cell).
// result:  exactly one word per command, in order: cursor after the command,
//          the cell written or read, and a scroll flag.
// cfg_wr_en / cfg_wr_data: text color for put and for rows blanked by scroll;
//          write it only while no command is in flight.
// A command goes from the decoder through the queue to the back end, which
// registers its result; a read first waits a state for the registered RAM word.
// A put or newline that scrolls copies every cell below the top row one row
// up through the single cell RAM port pair, one cell per cycle, then blanks
// the bottom row. Writes run at one command per cycle while results are taken.
// A two-entry queue sits between the decoder and the executing back end, and
// the result sits in an output register, so request keeps flowing while the
// receiver stalls until the queue fills.
// Reset: cursor to 0,0, color to 7, then a clearing pass over all COLUMNS*ROWS
// cells fills the buffer with light grey spaces; request.ready stays low.
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COLOR_W-1:0] cfg_wr_data,
    tcw_req_if.sink            request,
    tcw_res_if.source          result
);

    logic         push_valid, push_ready;
    tcw_op_t      push_op;
    logic         pop_valid, pop_ready;
    tcw_op_t      pop_op;
    back_status_t status;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (request),
        .status      (status),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_op     (push_op)
    );

    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (pop_valid),
        .op_ready (pop_ready),
        .op       (pop_op),
        .status   (status),
        .result   (result)
    );

endmodule

>>> src/tcw_checker.sv
`include "text_console_writer_defines.svh"

module tcw_checker import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   res_valid,
    input logic                   res_ready,
    input logic [COL_FIELD_W-1:0] res_column,
    input logic [ROW_FIELD_W-1:0] res_row,
    input logic [CELL_W-1:0]      res_cell,
    input logic                   res_scrolled
);

    localparam int PW = $clog2(QUEUE_DEPTH + 3) + 1;

    logic [PW-1:0] pending_reg;
    logic          req_take, res_take;

    assign req_take = req_valid && req_ready;
    assign res_take = res_valid && res_ready;

    // words accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (req_take && !res_take)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (res_take && !req_take)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    `TCW_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res_cell) && $stable(res_column) && $stable(res_row),
        "result word dropped or changed while stalled")

    `TCW_ASSERT_NOW(a_scroll_cursor, clk, rst_n, res_valid && res_scrolled,
        (res_column == '0) && (res_row == ROW_FIELD_W'(ROWS - 1)),
        "scroll did not leave cursor at start of bottom row")

    `TCW_ASSERT_NOW(a_cursor_range, clk, rst_n, res_valid,
        (int'(res_column) < COLUMNS) && (int'(res_row) < ROWS),
        "cursor outside the screen")

    `TCW_ASSERT_NOW(a_no_orphan, clk, rst_n, res_valid,
        pending_reg != '0,
        "result word without an accepted request")

    `TCW_ASSERT_NOW(a_bounded, clk, rst_n, 1'b1,
        pending_reg <= PW'(QUEUE_DEPTH + 1),
        "more words in flight than queue and output can hold")

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (request.valid),
    .req_ready    (request.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_column   (result.cursor_column),
    .res_row      (result.cursor_row),
    .res_cell     (result.cell_data),
    .res_scrolled (result.scrolled)
);

>>> tb/text_console_writer_tb.sv
`timescale 1ns / 100ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int TB_COLS       = 80;
    localparam int TB_ROWS       = 25;
    localparam int SCREEN_CELLS  = TB_COLS * TB_ROWS;
    localparam int CMD_UNUSED    = 3;
    localparam int LONG_GAP_MAX  = 40;
    // worst case per word: sender gap + receiver stall + pipeline
    localparam int WORD_BUDGET   = 2 * LONG_GAP_MAX + 4;
    localparam int SCROLL_BUDGET = SCREEN_CELLS + 10;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic [CMD_W-1:0]       command;
        logic [CHAR_W-1:0]      character;
        logic [COLOR_W-1:0]     cell_color;
        logic [COL_FIELD_W-1:0] column_x;
        logic [ROW_FIELD_W-1:0] row_y;
    } console_cmd_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [COLOR_W-1:0] cfg_wr_data;

    tcw_req_if request_bus ();
    tcw_res_if result_bus ();

    text_console_writer #(
        .COLUMNS (TB_COLS),
        .ROWS    (TB_ROWS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (request_bus),
        .result      (result_bus)
    );

    // shadow copy of the console
    logic [CELL_W-1:0]  screen [SCREEN_CELLS];
    int unsigned        cur_col;
    int unsigned        cur_row;
    logic [COLOR_W-1:0] text_color;

    console_cmd_t cmd_backlog [$];
    tcw_res_t     predicted_replies [$];
    console_cmd_t word_on_bus;

    int unsigned errors;
    int unsigned accepted_count;
    int unsigned checked_count;
    int unsigned scroll_count;
    int unsigned color_writes;
    int unsigned cycle_count;
    int unsigned run_limit;
    int unsigned idle_pct;
    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned hold_left;
    int unsigned hold_base;
    logic        hold_armed;
    logic        hold_done;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic line_feed();
        cur_col = 0;
        if (cur_row >= TB_ROWS - 1)
        begin
            cur_row = TB_ROWS - 1;
            for (int i = 0; i < SCREEN_CELLS - TB_COLS; i++)
                screen[i] = screen[i + TB_COLS];
            for (int i = SCREEN_CELLS - TB_COLS; i < SCREEN_CELLS; i++)
                screen[i] = {text_color, CH_SPACE};
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    function automatic tcw_res_t apply_console_cmd(console_cmd_t w);
        tcw_res_t          r;
        logic              in_range;
        logic [CELL_W-1:0] new_word;
        r        = '0;
        in_range = (w.column_x < TB_COLS) && (w.row_y < TB_ROWS);
        case (w.command)
            CMD_PUT:
            begin
                if (w.character == CH_NEWLINE)
                    r.scrolled = line_feed();
                else if (w.character == CH_RETURN)
                    cur_col = 0;
                else
                begin
                    new_word = {text_color, w.character};
                    screen[cur_row * TB_COLS + cur_col] = new_word;
                    r.cell_data = new_word;
                    cur_col++;
                    if (cur_col >= TB_COLS)
                        r.scrolled = line_feed();
                end
            end
            CMD_PUT_AT:
            begin
                if (in_range)
                begin
                    new_word = {w.cell_color, w.character};
                    screen[w.row_y * TB_COLS + w.column_x] = new_word;
                    r.cell_data = new_word;
                end
            end
            CMD_READ:
            begin
                if (in_range)
                    r.cell_data = screen[w.row_y * TB_COLS + w.column_x];
            end
            default: ;
        endcase
        r.cursor_column = cur_col[COL_FIELD_W-1:0];
        r.cursor_row    = cur_row[ROW_FIELD_W-1:0];
        return r;
    endfunction

    function automatic console_cmd_t make_cmd(int unsigned cmd, int unsigned ch,
                                              int unsigned color, int unsigned x,
                                              int unsigned y);
        console_cmd_t w;
        w.command    = cmd[CMD_W-1:0];
        w.character  = ch[CHAR_W-1:0];
        w.cell_color = color[COLOR_W-1:0];
        w.column_x   = x[COL_FIELD_W-1:0];
        w.row_y      = y[ROW_FIELD_W-1:0];
        return w;
    endfunction

    // cursor put with random don't-care fields
    function automatic console_cmd_t put_char(int unsigned ch);
        return make_cmd(CMD_PUT, ch, $urandom_range(0, 255), $urandom_range(0, 127),
                        $urandom_range(0, 31));
    endfunction

    // mostly short, a few long
    function automatic int unsigned pick_idle();
        if (idle_pct == 0 || $urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, LONG_GAP_MAX);
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request_bus.valid && request_bus.ready)
            begin
                tcw_res_t r;
                r = apply_console_cmd(word_on_bus);
                if (r.scrolled)
                    scroll_count++;
                predicted_replies.push_back(r);
                accepted_count++;
            end
            if (!request_bus.valid || request_bus.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    request_bus.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    word_on_bus = cmd_backlog.pop_front();
                    request_bus.command    <= word_on_bus.command;
                    request_bus.character  <= word_on_bus.character;
                    request_bus.cell_color <= word_on_bus.cell_color;
                    request_bus.column_x   <= word_on_bus.column_x;
                    request_bus.row_y      <= word_on_bus.row_y;
                    request_bus.valid      <= 1'b1;
                    send_gap = pick_idle();
                end
                else
                    request_bus.valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                tcw_res_t got;
                tcw_res_t want;
                got.cursor_column = result_bus.cursor_column;
                got.cursor_row    = result_bus.cursor_row;
                got.cell_data     = result_bus.cell_data;
                got.scrolled      = result_bus.scrolled;
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    checked_count++;
                    if (got.cursor_column !== want.cursor_column)
                    begin
                        $display("%0t: cursor_column expected %0d actual %0d",
                                 $time, want.cursor_column, got.cursor_column);
                        errors++;
                    end
                    if (got.cursor_row !== want.cursor_row)
                    begin
                        $display("%0t: cursor_row expected %0d actual %0d",
                                 $time, want.cursor_row, got.cursor_row);
                        errors++;
                    end
                    if (got.cell_data !== want.cell_data)
                    begin
                        $display("%0t: cell_data expected %h actual %h",
                                 $time, want.cell_data, got.cell_data);
                        errors++;
                    end
                    if (got.scrolled !== want.scrolled)
                    begin
                        $display("%0t: scrolled expected %b actual %b",
                                 $time, want.scrolled, got.scrolled);
                        errors++;
                    end
                end
            end
            if (hold_left != 0)
                result_bus.ready <= 1'b0;
            else if (recv_stall != 0)
            begin
                recv_stall--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                recv_stall = pick_idle();
            end
        end
    end

    // one long receiver hold-off so the internal queue fills and request stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (!hold_done && hold_armed && accepted_count >= hold_base + HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    task automatic queue_cmd(console_cmd_t w, inout int unsigned n,
                             inout int unsigned scroll_bound);
        cmd_backlog.push_back(w);
        n++;
        if (w.command == CMD_PUT && w.character == CH_NEWLINE)
            scroll_bound++;
    endtask

    task automatic fill_random(int unsigned target);
        int unsigned n;
        int unsigned scroll_bound;
        int unsigned kind;
        int unsigned len;
        int unsigned x;
        int unsigned y;
        n            = 0;
        scroll_bound = 0;
        while (n < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                // a line of text, sometimes long enough to wrap
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 40);
                for (int i = 0; i < len; i++)
                    queue_cmd(put_char(($urandom_range(0, 9) == 0) ?
                                       $urandom_range(0, 255) : $urandom_range(32, 126)),
                              n, scroll_bound);
                scroll_bound += len / TB_COLS + 1;
                case ($urandom_range(0, 9))
                    0, 1, 2: queue_cmd(put_char(CH_NEWLINE), n, scroll_bound);
                    3, 4:    queue_cmd(put_char(CH_RETURN), n, scroll_bound);
                    default: ;
                endcase
            end
            else if (kind < 62)
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    queue_cmd(put_char(CH_NEWLINE), n, scroll_bound);
            end
            else if (kind < 92)
            begin
                // read back, often after a write, mostly in range
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    x = ($urandom_range(0, 9) == 0) ? $urandom_range(TB_COLS, 127)
                                                    : $urandom_range(0, TB_COLS - 1);
                    y = ($urandom_range(0, 9) == 0) ? $urandom_range(TB_ROWS, 31)
                                                    : $urandom_range(0, TB_ROWS - 1);
                    if ($urandom_range(0, 2) != 0)
                        queue_cmd(make_cmd(CMD_PUT_AT, $urandom_range(0, 255),
                                           $urandom_range(0, 255), x, y), n, scroll_bound);
                    queue_cmd(make_cmd(CMD_READ, $urandom_range(0, 255),
                                       $urandom_range(0, 255), x, y), n, scroll_bound);
                end
            end
            else
                queue_cmd(make_cmd($urandom_range(0, CMD_UNUSED), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 127),
                                   $urandom_range(0, 31)), n, scroll_bound);
        end
        run_limit += 3 * (n * WORD_BUDGET + scroll_bound * SCROLL_BUDGET);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || request_bus.valid || predicted_replies.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_text_color(logic [COLOR_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        text_color = value;
        color_writes++;
    endtask

    // watchdog
    initial
    begin
        cycle_count = 0;
        do
        begin
            @(posedge clk);
            cycle_count++;
        end
        while (cycle_count < run_limit);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned n;
        int unsigned sb;
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        request_bus.valid      = 1'b0;
        request_bus.command    = '0;
        request_bus.character  = '0;
        request_bus.cell_color = '0;
        request_bus.column_x   = '0;
        request_bus.row_y      = '0;
        result_bus.ready       = 1'b0;
        errors         = 0;
        accepted_count = 0;
        checked_count  = 0;
        scroll_count   = 0;
        color_writes   = 0;
        send_gap       = 0;
        recv_stall     = 0;
        hold_left      = 0;
        hold_base      = 0;
        hold_armed     = 1'b0;
        hold_done      = 1'b0;
        idle_pct       = 20;
        cur_col        = 0;
        cur_row        = 0;
        text_color     = RESET_COLOR;
        n              = 0;
        sb             = 0;
        for (int i = 0; i < SCREEN_CELLS; i++)
            screen[i] = CLEAR_CELL;
        // clearing pass, hold-off and the directed words
        run_limit = 3 * (2 * SCREEN_CELLS + HOLD_CYCLES + 30 * WORD_BUDGET + 100);

        // directed: fresh buffer, field extremes, controls, out-of-range positions
        queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 0), n, sb);
        queue_cmd(make_cmd(CMD_READ, 0, 0, TB_COLS - 1, TB_ROWS - 1), n, sb);
        queue_cmd(put_char(8'h41), n, sb);
        queue_cmd(put_char(8'h00), n, sb);
        queue_cmd(put_char(8'hFF), n, sb);
        queue_cmd(put_char(CH_RETURN), n, sb);
        queue_cmd(put_char(8'h42), n, sb);
        queue_cmd(put_char(CH_NEWLINE), n, sb);
        queue_cmd(make_cmd(CMD_PUT_AT, 8'hFF, 8'hFF, 0, 0), n, sb);
        queue_cmd(make_cmd(CMD_PUT_AT, 8'h00, 8'h00, TB_COLS - 1, TB_ROWS - 1), n, sb);
        queue_cmd(make_cmd(CMD_PUT_AT, 8'h55, 8'hAA, TB_COLS, 0), n, sb);
        queue_cmd(make_cmd(CMD_PUT_AT, 8'h55, 8'hAA, 0, TB_ROWS), n, sb);
        queue_cmd(make_cmd(CMD_PUT_AT, 8'hFF, 8'hFF, 127, 31), n, sb);
        queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 0), n, sb);
        queue_cmd(make_cmd(CMD_READ, 0, 0, TB_COLS - 1, TB_ROWS - 1), n, sb);
        queue_cmd(make_cmd(CMD_READ, 8'hFF, 8'hFF, 127, 31), n, sb);
        queue_cmd(make_cmd(CMD_READ, 0, 0, 0, TB_ROWS), n, sb);
        queue_cmd(make_cmd(CMD_READ, 0, 0, 1, 0), n, sb);
        queue_cmd(make_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 127, 31), n, sb);
        queue_cmd(make_cmd(CMD_UNUSED, 0, 0, 0, 0), n, sb);
        queue_cmd(put_char(8'h5A), n, sb);

        @(negedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait_drained();

        set_text_color(8'h00);
        idle_pct = 25;
        fill_random(150);
        wait_drained();

        set_text_color(8'hFF);
        idle_pct = 40;
        fill_random(300);
        wait_drained();

        // back-to-back stretch; the receiver hold-off lands here
        set_text_color(COLOR_W'($urandom_range(0, 255)));
        idle_pct   = 0;
        hold_base  = accepted_count;
        hold_armed = 1'b1;
        fill_random(200);
        wait_drained();

        set_text_color(8'h1E);
        idle_pct = 20;
        fill_random(260);
        wait_drained();
        repeat (10) @(negedge clk);

        if (predicted_replies.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, predicted_replies.size());
            errors++;
        end
        $display("Ran %0d commands across %0d text colors, %0d scrolls predicted",
                 accepted_count, color_writes + 1, scroll_count);
        $display("Checked %0d result words, %0d mismatches", checked_count, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/tcw_pkg.sv
src/tcw_ifs.sv
src/tcw_ram.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer.sv
src/tcw_checker.sv
tb/text_console_writer_tb.sv
